@@ hw/rtl/achc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacent channel hit clusterer package
// Shared widths, register indexes, table entry and cluster types, and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package achc_pkg;

   localparam int CHAN_W  = 7;   // signed hit channel, also slot channel math
   localparam int MOD_W   = 4;
   localparam int AMP_W   = 12;
   localparam int TM_W    = 12;
   localparam int OCH_W   = 6;   // channel field width on the result side
   localparam int SLOTF_W = 5;   // cluster slot field width

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_SEED_THR    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLUSTER_THR = 1'b1;

   localparam logic signed [AMP_W-1:0] THR_RESET = 12'sd30;

   typedef struct packed {
      logic [MOD_W-1:0]        mod_id;
      logic signed [AMP_W-1:0] amp;
      logic signed [TM_W-1:0]  tm;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [SLOTF_W-1:0]      slot;
      logic                    cvalid;
      logic [OCH_W-1:0]        seed_ch;
      logic [MOD_W-1:0]        seed_mod;
      logic signed [AMP_W-1:0] seed_amp;
      logic signed [TM_W-1:0]  seed_tm;
      logic                    sec_valid;
      logic [OCH_W-1:0]        sec_ch;
      logic [MOD_W-1:0]        sec_mod;
      logic signed [AMP_W-1:0] sec_amp;
      logic signed [TM_W-1:0]  sec_tm;
      logic                    last;
   } cluster_type;

   typedef enum logic [2:0] {
      ST_HIT,
      ST_RD_E,
      ST_CMP_E,
      ST_CMP_D1,
      ST_CMP_D2,
      ST_CMP_N,
      ST_OUT
   } state_type;

endpackage

@@ hw/rtl/achc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adjacent channel hit clusterer channel interfaces
// Valid/ready channels for hit requests and cluster results.
// ----------------------------------------------------------------------------
interface achc_req_if import achc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [CHAN_W-1:0] hit_channel;
   logic [MOD_W-1:0]         hit_module;
   logic signed [AMP_W-1:0]  hit_amplitude;
   logic signed [TM_W-1:0]   hit_time;
   logic                     last_hit;

   modport source (output valid, hit_channel, hit_module, hit_amplitude, hit_time,
                   last_hit, input ready);
   modport sink (input valid, hit_channel, hit_module, hit_amplitude, hit_time,
                 last_hit, output ready);
endinterface

interface achc_rsp_if import achc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SLOTF_W-1:0]      cluster_slot;
   logic                    cluster_valid;
   logic [OCH_W-1:0]        seed_channel;
   logic [MOD_W-1:0]        seed_module;
   logic signed [AMP_W-1:0] seed_amplitude;
   logic signed [TM_W-1:0]  seed_time;
   logic                    second_valid;
   logic [OCH_W-1:0]        second_channel;
   logic [MOD_W-1:0]        second_module;
   logic signed [AMP_W-1:0] second_amplitude;
   logic signed [TM_W-1:0]  second_time;
   logic                    last_cluster;

   modport source (output valid, cluster_slot, cluster_valid, seed_channel,
                   seed_module, seed_amplitude, seed_time, second_valid,
                   second_channel, second_module, second_amplitude, second_time,
                   last_cluster, input ready);
   modport sink (input valid, cluster_slot, cluster_valid, seed_channel,
                 seed_module, seed_amplitude, seed_time, second_valid,
                 second_channel, second_module, second_amplitude, second_time,
                 last_cluster, output ready);
endinterface

@@ hw/rtl/achc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module achc_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/achc_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared amplitude comparator
// Signed strict greater-than of an amplitude against a threshold.
// ----------------------------------------------------------------------------
module achc_cmp import achc_pkg::*; (
   input  logic signed [AMP_W-1:0] amp,
   input  logic signed [AMP_W-1:0] thr,
   output logic                    gt
);

   assign gt = (amp > thr);

endmodule

@@ hw/rtl/adjacent_channel_hit_clusterer_top.sv @@
`timescale 1ns / 1ps
// Results of an event start once the first slot has passed through ST_RD_E, ST_CMP_E,
// ST_CMP_D1, ST_CMP_D2 and ST_CMP_N after the request carrying last_hit. Hit requests are
// taken one per cycle while the block is in ST_HIT; each cluster slot then walks those states
// and waits in ST_OUT on rsp ready, serial due to the single RAM read port and shared comparator.
// Reset is synchronous and active high. It clears the channel valid bits, the hit count
// and the sequencer and loads both thresholds with 30; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Adjacent channel hit clusterer
// Gathers the hits of an event into a channel table, then walks the cluster
// slots and emits one cluster per slot.
// ----------------------------------------------------------------------------
module adjacent_channel_hit_clusterer_top import achc_pkg::*; #(
   parameter int CHANNELS      = 64,
   parameter int CLUSTER_SLOTS = 32,
   parameter int MAX_HITS      = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   achc_req_if.sink              req_chan,
   achc_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SLOT_W = (CLUSTER_SLOTS > 1) ? $clog2(CLUSTER_SLOTS) : 1;
   localparam int CNT_W  = $clog2(MAX_HITS + 1);

   // Configuration registers. They must only be written while the block is idle; the block does not enforce this.
   logic signed [AMP_W-1:0] seed_thr_ff, cluster_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_thr_ff    <= THR_RESET;
         cluster_thr_ff <= THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEED_THR:    seed_thr_ff    <= csr_wdata;
            CSR_CLUSTER_THR: cluster_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer and walk state.
   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CHANNELS-1:0]  valid_ff, valid_in;
   // Set when the previous slot took this slot's even channel as its secondary.
   logic                 taken_ff, taken_in;
   logic                 e_seed_ff, e_seed_in;
   logic                 d_join_ff, d_join_in;
   logic                 d_seed_ff, d_seed_in;
   entry_type            e_ent_ff, e_ent_in;
   entry_type            d_ent_ff, d_ent_in;
   cluster_type          rsp_ff, rsp_in;

   // Hit side.
   logic                 req_fire;
   logic                 hit_in_range;
   logic                 hit_store;
   logic [IDX_W-1:0]     hit_idx;
   entry_type            hit_ent;

   assign req_chan.ready = (state_ff == ST_HIT);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign hit_in_range   = !req_chan.hit_channel[CHAN_W-1] &&
                           ($unsigned(req_chan.hit_channel) < CHAN_W'(CHANNELS));
   assign hit_store      = req_fire && hit_in_range && (count_ff < CNT_W'(MAX_HITS));
   assign hit_idx        = req_chan.hit_channel[IDX_W-1:0];
   assign hit_ent.mod_id = req_chan.hit_module;
   assign hit_ent.amp    = req_chan.hit_amplitude;
   assign hit_ent.tm     = req_chan.hit_time;

   // Channels of the current slot: even 2k, odd 2k+1 and next 2k+2.
   logic [CHAN_W-1:0]    e_ch, d_ch, n_ch;
   logic                 e_present, d_present, n_present;
   logic                 slot_last;

   assign e_ch      = CHAN_W'({slot_ff, 1'b0});
   assign d_ch      = e_ch | CHAN_W'(1);
   assign n_ch      = e_ch + CHAN_W'(2);
   assign e_present = (e_ch < CHAN_W'(CHANNELS)) && valid_ff[e_ch[IDX_W-1:0]];
   assign d_present = (d_ch < CHAN_W'(CHANNELS)) && valid_ff[d_ch[IDX_W-1:0]];
   assign n_present = (n_ch < CHAN_W'(CHANNELS)) && valid_ff[n_ch[IDX_W-1:0]];
   assign slot_last = (slot_ff == SLOT_W'(CLUSTER_SLOTS - 1));

   // Table memory: module, amplitude and time. Presence is kept in valid_ff.
   logic [IDX_W-1:0]    rd_addr;
   logic [ENTRY_W-1:0]  rd_word;
   entry_type           rd_ent;

   always_comb begin
      case (state_ff)
         ST_RD_E:             rd_addr = e_ch[IDX_W-1:0];
         ST_CMP_E, ST_CMP_D1: rd_addr = d_ch[IDX_W-1:0];
         default:             rd_addr = n_ch[IDX_W-1:0];
      endcase
   end

   achc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_table (
      .clock (clock),
      .we    (hit_store),
      .waddr (hit_idx),
      .wdata (hit_ent),
      .raddr (rd_addr),
      .rdata (rd_word)
   );

   assign rd_ent = rd_word;

   // The one comparator is shared by all four threshold tests of a slot.
   logic signed [AMP_W-1:0] cmp_amp, cmp_thr;
   logic                    cmp_gt;

   always_comb begin
      case (state_ff)
         ST_CMP_E: begin
            cmp_amp = rd_ent.amp;
            cmp_thr = seed_thr_ff;
         end
         ST_CMP_D2: begin
            cmp_amp = d_ent_ff.amp;
            cmp_thr = seed_thr_ff;
         end
         default: begin
            cmp_amp = rd_ent.amp;
            cmp_thr = cluster_thr_ff;
         end
      endcase
   end

   achc_cmp u_cmp (
      .amp (cmp_amp),
      .thr (cmp_thr),
      .gt  (cmp_gt)
   );

   // The next channel can join only when this is not the final slot.
   logic n_join;

   assign n_join = !slot_last && n_present && cmp_gt;

   always_comb begin
      state_in  = state_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      taken_in  = taken_ff;
      e_seed_in = e_seed_ff;
      d_join_in = d_join_ff;
      d_seed_in = d_seed_ff;
      e_ent_in  = e_ent_ff;
      d_ent_in  = d_ent_ff;
      rsp_in    = rsp_ff;

      case (state_ff)
         ST_HIT: begin
            if (req_fire) begin
               if (hit_store) begin
                  valid_in[hit_idx] = 1'b1;
               end
               if (count_ff < CNT_W'(MAX_HITS)) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_chan.last_hit) begin
                  state_in = ST_RD_E;
                  slot_in  = '0;
                  taken_in = 1'b0;
               end
            end
         end
         ST_RD_E: begin
            state_in = ST_CMP_E;
         end
         ST_CMP_E: begin
            e_seed_in = e_present && !taken_ff && cmp_gt;
            e_ent_in  = rd_ent;
            state_in  = ST_CMP_D1;
         end
         ST_CMP_D1: begin
            d_join_in = d_present && cmp_gt;
            d_ent_in  = rd_ent;
            state_in  = ST_CMP_D2;
         end
         ST_CMP_D2: begin
            d_seed_in = d_present && cmp_gt;
            state_in  = ST_CMP_N;
         end
         ST_CMP_N: begin
            rsp_in      = '0;
            rsp_in.slot = SLOTF_W'(slot_ff);
            rsp_in.last = slot_last;
            taken_in    = 1'b0;
            if (e_seed_ff && d_join_ff) begin
               // Even seed with the odd channel as its secondary.
               rsp_in.cvalid    = 1'b1;
               rsp_in.seed_ch   = e_ch[OCH_W-1:0];
               rsp_in.seed_mod  = e_ent_ff.mod_id;
               rsp_in.seed_amp  = e_ent_ff.amp;
               rsp_in.seed_tm   = e_ent_ff.tm;
               rsp_in.sec_valid = 1'b1;
               rsp_in.sec_ch    = d_ch[OCH_W-1:0];
               rsp_in.sec_mod   = d_ent_ff.mod_id;
               rsp_in.sec_amp   = d_ent_ff.amp;
               rsp_in.sec_tm    = d_ent_ff.tm;
            end else if (d_seed_ff) begin
               // The odd channel reseeds and may pull in the next channel.
               rsp_in.cvalid   = 1'b1;
               rsp_in.seed_ch  = d_ch[OCH_W-1:0];
               rsp_in.seed_mod = d_ent_ff.mod_id;
               rsp_in.seed_amp = d_ent_ff.amp;
               rsp_in.seed_tm  = d_ent_ff.tm;
               if (n_join) begin
                  rsp_in.sec_valid = 1'b1;
                  rsp_in.sec_ch    = n_ch[OCH_W-1:0];
                  rsp_in.sec_mod   = rd_ent.mod_id;
                  rsp_in.sec_amp   = rd_ent.amp;
                  rsp_in.sec_tm    = rd_ent.tm;
                  taken_in         = 1'b1;
               end
            end else if (e_seed_ff) begin
               rsp_in.cvalid   = 1'b1;
               rsp_in.seed_ch  = e_ch[OCH_W-1:0];
               rsp_in.seed_mod = e_ent_ff.mod_id;
               rsp_in.seed_amp = e_ent_ff.amp;
               rsp_in.seed_tm  = e_ent_ff.tm;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               if (slot_last) begin
                  // Event done: drop the table for the next event.
                  valid_in = '0;
                  count_in = '0;
                  taken_in = 1'b0;
                  state_in = ST_HIT;
               end else begin
                  slot_in  = slot_ff + SLOT_W'(1);
                  state_in = ST_RD_E;
               end
            end
         end
         default: begin
            state_in = ST_HIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HIT;
         slot_ff  <= '0;
         count_ff <= '0;
         valid_ff <= '0;
         taken_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
         taken_ff <= taken_in;
      end
   end

   always_ff @(posedge clock) begin
      e_seed_ff <= e_seed_in;
      d_join_ff <= d_join_in;
      d_seed_ff <= d_seed_in;
      e_ent_ff  <= e_ent_in;
      d_ent_ff  <= d_ent_in;
      rsp_ff    <= rsp_in;
   end

   // Result channel.
   assign rsp_chan.valid            = (state_ff == ST_OUT);
   assign rsp_chan.cluster_slot     = rsp_ff.slot;
   assign rsp_chan.cluster_valid    = rsp_ff.cvalid;
   assign rsp_chan.seed_channel     = rsp_ff.seed_ch;
   assign rsp_chan.seed_module      = rsp_ff.seed_mod;
   assign rsp_chan.seed_amplitude   = rsp_ff.seed_amp;
   assign rsp_chan.seed_time        = rsp_ff.seed_tm;
   assign rsp_chan.second_valid     = rsp_ff.sec_valid;
   assign rsp_chan.second_channel   = rsp_ff.sec_ch;
   assign rsp_chan.second_module    = rsp_ff.sec_mod;
   assign rsp_chan.second_amplitude = rsp_ff.sec_amp;
   assign rsp_chan.second_time      = rsp_ff.sec_tm;
   assign rsp_chan.last_cluster     = rsp_ff.last;

endmodule
